### src/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the error statistics checker.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    // Fixed field widths
    localparam int unsigned DATA_W  = 24;
    localparam int unsigned POS_W   = 16;
    localparam int unsigned SUM_W   = 64;
    localparam int unsigned ROOT_W  = 32;
    localparam int unsigned SREM_W  = 34;
    localparam int unsigned STEP_W  = 6;
    localparam int unsigned IDX_W   = 8;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_RMS_LIMIT = 8'd0;
    localparam logic [IDX_W-1:0] REG_MAX_LIMIT = 8'd1;

    // Last iteration of the divider (64 quotient bits) and of the root (32 bits)
    localparam logic [STEP_W-1:0]   DIV_LAST_STEP  = 6'd63;
    localparam logic [STEP_W-2:0]   SQRT_LAST_STEP = 5'd31;

    // Controller states
    typedef enum logic [2:0] {
        ST_ACC,
        ST_FLUSH0,
        ST_FLUSH1,
        ST_LOAD,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // input word taken this cycle
        logic load;       // load divider with sum and count
        logic div_step;   // one quotient bit
        logic sqrt_step;  // one root bit
        logic finish;     // load result register, clear statistics
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
        logic sqrt_last;
        logic out_busy;   // result register full and not taken
    } t_stat;

endpackage

`default_nettype wire

### src/esc_ctrl.sv
// ----------------------------------------------------------------------------
// esc_ctrl
// Controller: runs accumulation, flush, divide, square root and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_ctrl
    import esc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_in_last,
    input  wire t_stat i_stat,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACC: begin
                if (i_in_valid && i_in_last) begin
                    n_state = ST_FLUSH0;
                end
            end
            ST_FLUSH0: n_state = ST_FLUSH1;
            ST_FLUSH1: n_state = ST_LOAD;
            ST_LOAD:   n_state = ST_DIV;
            ST_DIV: begin
                if (i_stat.div_last) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (i_stat.sqrt_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_stat.out_busy) begin
                    n_state = ST_ACC;
                end
            end
            default: n_state = ST_ACC;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_ACC: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_LOAD: o_cmd.load      = 1'b1;
            ST_DIV:  o_cmd.div_step  = 1'b1;
            ST_SQRT: o_cmd.sqrt_step = 1'b1;
            ST_DONE: o_cmd.finish    = !i_stat.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### src/esc_dp.sv
// ----------------------------------------------------------------------------
// esc_dp
// Datapath: error pipeline, statistics, shared divide / root unit, result word.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_dp
    import esc_pkg::*;
#(
    parameter int unsigned MAX_ITEMS    = 65536,
    parameter int unsigned SAMPLE_WIDTH = 24
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    input  wire logic [DATA_W-1:0]   i_actual,
    input  wire logic [DATA_W-1:0]   i_reference,
    input  wire logic                i_cfg_valid,
    input  wire logic [IDX_W-1:0]    i_cfg_index,
    input  wire logic [DATA_W-1:0]   i_cfg_data,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [DATA_W-1:0]        o_rms_error,
    output logic [DATA_W-1:0]        o_max_error,
    output logic [POS_W-1:0]         o_max_position,
    output logic [DATA_W-1:0]        o_first_error,
    output logic [POS_W-1:0]         o_first_position,
    output logic                     o_pass
);

    localparam int unsigned CW   = $clog2(MAX_ITEMS + 1);
    localparam int unsigned EXTW = DATA_W + 1 - SAMPLE_WIDTH;

    // Configuration
    logic [DATA_W-1:0] r_rms_limit;
    logic [DATA_W-1:0] r_max_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rms_limit <= '0;
            r_max_limit <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_RMS_LIMIT) begin
                r_rms_limit <= i_cfg_data;
            end
            if (i_cfg_index == REG_MAX_LIMIT) begin
                r_max_limit <= i_cfg_data;
            end
        end
    end

    // Stage 0: sign extend, difference, magnitude, clamped index
    logic signed [DATA_W:0] w_act;
    logic signed [DATA_W:0] w_ref;
    logic signed [DATA_W:0] w_diff;
    logic [DATA_W:0]        w_mag;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          w_idx_c;
    logic [31:0]            w_idx_w;
    logic [POS_W-1:0]       w_idx;

    assign w_act  = {{EXTW{i_actual[SAMPLE_WIDTH-1]}}, i_actual[SAMPLE_WIDTH-1:0]};
    assign w_ref  = {{EXTW{i_reference[SAMPLE_WIDTH-1]}}, i_reference[SAMPLE_WIDTH-1:0]};
    assign w_diff = w_act - w_ref;
    assign w_mag  = w_diff[DATA_W] ? (DATA_W+1)'(-w_diff) : w_diff;

    assign w_idx_c = (r_count < CW'(MAX_ITEMS)) ? r_count : CW'(MAX_ITEMS - 1);
    assign w_idx_w = 32'(w_idx_c);
    assign w_idx   = (w_idx_w > 32'hFFFF) ? '1 : w_idx_w[POS_W-1:0];

    // Stage 1 and 2 registers
    logic                     r_s1_valid;
    logic [DATA_W-1:0]        r_s1_err;
    logic [POS_W-1:0]         r_s1_idx;
    logic                     r_s2_valid;
    logic [2*DATA_W-1:0]      r_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_err <= w_mag[DATA_W-1:0];
        r_s1_idx <= w_idx;
        r_sq     <= r_s1_err * r_s1_err;
    end

    // Statistics
    logic [SUM_W-1:0]  r_sum;
    logic [DATA_W-1:0] r_largest;
    logic [POS_W-1:0]  r_largest_idx;
    logic [DATA_W-1:0] r_early;
    logic [POS_W-1:0]  r_early_idx;
    logic              r_early_seen;
    logic [SUM_W:0]    w_sum_add;

    assign w_sum_add = {1'b0, r_sum} + (SUM_W+1)'(r_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_sum         <= '0;
            r_count       <= '0;
            r_largest     <= '0;
            r_largest_idx <= '0;
            r_early       <= '0;
            r_early_idx   <= '0;
            r_early_seen  <= 1'b0;
        end else begin
            // saturating pair count
            if (i_cmd.accept && (r_count != CW'(MAX_ITEMS))) begin
                r_count <= r_count + 1'b1;
            end
            // first error above the limit, and largest error on strict greater
            if (r_s1_valid) begin
                if (!r_early_seen && (r_s1_err > r_max_limit)) begin
                    r_early_seen <= 1'b1;
                    r_early      <= r_s1_err;
                    r_early_idx  <= r_s1_idx;
                end
                if (r_s1_err > r_largest) begin
                    r_largest     <= r_s1_err;
                    r_largest_idx <= r_s1_idx;
                end
            end
            // saturating sum of squares
            if (r_s2_valid) begin
                r_sum <= w_sum_add[SUM_W] ? '1 : w_sum_add[SUM_W-1:0];
            end
        end
    end

    // Shared divide / root unit: restoring divide, then digit-by-digit root
    // on the quotient shifted out two bits a step.
    logic [SUM_W-1:0]  r_quo;
    logic [CW-1:0]     r_drem;
    logic [CW-1:0]     r_div;
    logic [STEP_W-1:0] r_step;
    logic [ROOT_W-1:0] r_root;
    logic [SREM_W-1:0] r_srem;

    logic [CW:0]       w_dtry;
    logic              w_dge;
    logic [CW:0]       w_dsub;
    logic [SREM_W+1:0] w_stry;
    logic [SREM_W+1:0] w_strial;
    logic              w_sge;
    logic [SREM_W+1:0] w_ssub;

    assign w_dtry   = {r_drem, r_quo[SUM_W-1]};
    assign w_dge    = w_dtry >= {1'b0, r_div};
    assign w_dsub   = w_dtry - {1'b0, r_div};

    assign w_stry   = {r_srem, r_quo[SUM_W-1:SUM_W-2]};
    assign w_strial = {2'b00, r_root, 2'b01};
    assign w_sge    = w_stry >= w_strial;
    assign w_ssub   = w_stry - w_strial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo  <= r_sum;
            r_div  <= r_count;
            r_drem <= '0;
            r_step <= '0;
            r_root <= '0;
            r_srem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[SUM_W-2:0], w_dge};
            r_drem <= w_dge ? w_dsub[CW-1:0] : w_dtry[CW-1:0];
            r_step <= r_step + 1'b1;
        end else if (i_cmd.sqrt_step) begin
            r_quo  <= {r_quo[SUM_W-3:0], 2'b00};
            r_srem <= w_sge ? w_ssub[SREM_W-1:0] : w_stry[SREM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_sge};
            r_step <= r_step + 1'b1;
        end
    end

    // Result register
    logic [DATA_W-1:0] w_rms;

    assign w_rms = r_root[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_rms_error      <= w_rms;
            o_max_error      <= r_largest;
            o_max_position   <= r_largest_idx;
            o_first_error    <= r_early_seen ? r_early : '0;
            o_first_position <= r_early_seen ? r_early_idx : '0;
            o_pass           <= (w_rms <= r_rms_limit) && (r_largest <= r_max_limit);
        end
    end

    // Status
    assign o_stat.div_last  = (r_step == DIV_LAST_STEP);
    assign o_stat.sqrt_last = (r_step[STEP_W-2:0] == SQRT_LAST_STEP);
    assign o_stat.out_busy  = o_out_valid && !i_out_ready;

endmodule

`default_nettype wire

### src/error_statistics_checker.sv
// ----------------------------------------------------------------------------
// error_statistics_checker
// RMS, maximum and first-excess error of a stream of sample pairs.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready tdata 48b, tlast
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata 112b
//  cfg       in         i_cfg_valid/o_cfg_ready         index 8b, data 24b
//
//  One pair per cycle while a data set streams in (two-stage error pipeline).
//  After the pair marked last, s_axis stalls through ST_FLUSH0, ST_FLUSH1,
//  ST_LOAD, 64 divide steps and 32 root steps on the shared iterative unit, and
//  the load of the result register (held off while m_axis holds it full).
//  A waiting result does not block the next data set.
//  Synchronous active-low reset clears statistics and limits; cfg is always
//  ready.
// ----------------------------------------------------------------------------
`default_nettype none

module error_statistics_checker
    import esc_pkg::*;
#(
    parameter int unsigned MAX_ITEMS    = 65536,
    parameter int unsigned SAMPLE_WIDTH = 24
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [23:0] actual_sample, [47:24] reference_sample
    input  wire logic [47:0]       i_s_axis_tdata,
    input  wire logic              i_s_axis_tlast,
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    // [23:0] rms_error, [47:24] max_error, [63:48] max_position,
    // [87:64] first_error, [103:88] first_position, [104] pass, [111:105] zero
    output logic [111:0]           o_m_axis_tdata,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [DATA_W-1:0] i_cfg_data
);

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [DATA_W-1:0] w_rms;
    logic [DATA_W-1:0] w_max;
    logic [POS_W-1:0]  w_max_pos;
    logic [DATA_W-1:0] w_first;
    logic [POS_W-1:0]  w_first_pos;
    logic              w_pass;

    assign o_cfg_ready = 1'b1;

    esc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_last  (i_s_axis_tlast),
        .i_stat     (w_stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    esc_dp #(
        .MAX_ITEMS    (MAX_ITEMS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_actual         (i_s_axis_tdata[23:0]),
        .i_reference      (i_s_axis_tdata[47:24]),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_rms_error      (w_rms),
        .o_max_error      (w_max),
        .o_max_position   (w_max_pos),
        .o_first_error    (w_first),
        .o_first_position (w_first_pos),
        .o_pass           (w_pass)
    );

    // Result word packing
    assign o_m_axis_tdata = {7'd0, w_pass, w_first_pos, w_first, w_max_pos, w_max, w_rms};

endmodule

`default_nettype wire

### src/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks of the error statistics checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic         i_s_axis_tlast,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [111:0] o_m_axis_tdata
);

    // A held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

    // After the last pair the input side stalls while the result is computed
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> !o_s_axis_tready)
        else $error("input taken right after the last pair");

    // A passing data set has no error above the limit
    a_pass_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[104] |->
        (o_m_axis_tdata[87:64] == 24'd0) && (o_m_axis_tdata[103:88] == 16'd0))
        else $error("pass with an excessive error reported");

    // The largest error bounds the first excessive one
    a_max_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[47:24] >= o_m_axis_tdata[87:64])
        else $error("first error above max error");

    // No result word right out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind error_statistics_checker esc_checker u_esc_checker (.*);

`default_nettype wire
